// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked invariant, disabled in reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/sfcrc_pkg.sv =====
// Package: types and constants of the serial frame CRC-16 check/append core.
`default_nettype none

package sfcrc_pkg;

    localparam int MAX_RES        = 3;
    localparam int FIFO_DEPTH_DEF = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;
    localparam int CMD_W          = 7;

    localparam logic [7:0]  SYNC_BYTE = 8'h55;
    localparam logic [7:0]  MIN_LEN   = 8'd4;
    localparam logic [7:0]  POS_MAX   = 8'hFF;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMMAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APPEND_MODE      = 2'd1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SYNC = 3'd1,
        ST_BAD_CMD  = 3'd2,
        ST_BAD_CRC  = 3'd3,
        ST_BAD_LEN  = 3'd4
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0] expected_command;
        logic             append_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       is_status;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/serial_frame_crc16_check_append_core.sv =====
// Top level: serial frame Modbus CRC-16 checker and appender.
//
//  channel | signals                                      | role
//  in      | in_valid in_ready data_byte frame_start      | frame bytes, one per beat
//  out     | out_valid out_ready out_byte status          | echoed/CRC bytes or frame
//          | is_status last                               | status, one per beat
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data       | register writes, always ready
//
// An input beat is taken every cycle while in_ready is high; its results are queued on
// the same edge and offered at the output from the next cycle. CRC update likewise is
// one byte per cycle. The last byte of an append frame yields up to three results,
// drained one per cycle while out_ready is high; in_ready drops while the queue has
// room for fewer than three. Reset clears frame state, registers and the queue.
`default_nettype none

module serial_frame_crc16_check_append_core #(
    parameter int FIFO_DEPTH = sfcrc_pkg::FIFO_DEPTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [7:0]                       data_byte,
    input  wire                              frame_start,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [7:0]                       out_byte,
    output logic [2:0]                       status,
    output logic                             is_status,
    output logic                             last,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [sfcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [sfcrc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sfcrc_pkg::*;

    `include "assert_macros.svh"

    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = LVL_W + 1;

    cfg_t               cfg_reg;
    logic               in_fire, pop;
    logic [1:0]         push_n;
    result_t            push_res [MAX_RES];
    result_t            head;
    logic               can_push;
    logic [LVL_W-1:0]   level;
    logic [SUM_W-1:0]   fill_sum;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_push;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (level != '0);
    assign pop       = out_valid && out_ready;
    assign out_byte  = head.out_byte;
    assign status    = head.status;
    assign is_status = head.is_status;
    assign last      = head.last;
    assign fill_sum  = {1'b0, level} + SUM_W'(push_n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '{expected_command: '0, append_mode: 1'b0};
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_EXPECTED_COMMAND: cfg_reg.expected_command <= cfg_data[CMD_W-1:0];
                CFG_APPEND_MODE:      cfg_reg.append_mode      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sfcrc_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .cfg         (cfg_reg),
        .push_n      (push_n),
        .push_res    (push_res)
    );

    sfcrc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_n   (push_n),
        .push_res (push_res),
        .pop      (pop),
        .can_push (can_push),
        .level    (level),
        .head     (head)
    );

    `ASSERT_ALWAYS(a_no_overflow, clk, rst_n, fill_sum <= SUM_W'(FIFO_DEPTH), "queue overflow")
    `ASSERT_IMPLY(a_push_only_on_beat, clk, rst_n, !in_fire, push_n == 2'd0, "push without beat")
    `ASSERT_IMPLY(a_status_is_last, clk, rst_n, out_valid && is_status, last, "status not last")

endmodule

`default_nettype wire

// ===== hw/rtl/sfcrc_frame.sv =====
// Frame tracker: position, length, CRC-16 and status; emits up to three results per beat.
`default_nettype none

module sfcrc_frame (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_fire,
    input  wire [7:0]            data_byte,
    input  wire                  frame_start,
    input  wire sfcrc_pkg::cfg_t cfg,
    output logic [1:0]           push_n,
    output sfcrc_pkg::result_t   push_res [sfcrc_pkg::MAX_RES]
);
    import sfcrc_pkg::*;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    status_t     ferr_reg, ferr_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic        done_reg, done_next;

    logic [7:0]  pos_e, len_e, crc_lo_e;
    logic [15:0] crc_e;
    status_t     ferr_e, st_v;
    logic        done_e, covered;
    logic [8:0]  pos_w;
    logic [1:0]  n_v;

    always_comb
    begin
        pos_e    = frame_start ? 8'd0 : pos_reg;
        len_e    = frame_start ? 8'd0 : len_reg;
        crc_e    = frame_start ? CRC_INIT : crc_reg;
        ferr_e   = frame_start ? ST_OK : ferr_reg;
        crc_lo_e = frame_start ? 8'd0 : crc_lo_reg;
        done_e   = frame_start ? 1'b0 : done_reg;

        pos_next    = pos_e;
        len_next    = len_e;
        crc_next    = crc_e;
        ferr_next   = ferr_e;
        crc_lo_next = crc_lo_e;
        done_next   = done_e;

        pos_w   = {1'b0, pos_e};
        covered = 1'b0;
        st_v    = ST_OK;
        n_v     = 2'd0;
        for (int k = 0; k < MAX_RES; k++)
            push_res[k] = '{out_byte: 8'h00, status: ST_OK, is_status: 1'b0, last: 1'b0};

        if (!done_e) begin
            if (pos_e == 8'd0 && data_byte != SYNC_BYTE && ferr_next == ST_OK)
                ferr_next = ST_BAD_SYNC;
            if (pos_e == 8'd3 && data_byte[CMD_W-1:0] != cfg.expected_command
                && ferr_next == ST_OK)
                ferr_next = ST_BAD_CMD;
            if (pos_e == 8'd2)
                len_next = data_byte;

            if (pos_e == 8'd2 && data_byte < MIN_LEN) begin
                st_v = ST_BAD_LEN;
                if (!cfg.append_mode && ferr_next != ST_OK)
                    st_v = ferr_next;
                push_res[0] = '{out_byte: 8'h00, status: st_v, is_status: 1'b1, last: 1'b1};
                n_v       = 2'd1;
                done_next = 1'b1;
            end else begin
                covered = (pos_e < 8'd2) || (pos_w + 9'd2 < {1'b0, len_next});
                if (covered)
                    crc_next = crc_byte(crc_e, data_byte);

                if (cfg.append_mode) begin
                    if (covered) begin
                        push_res[0] = '{out_byte: data_byte, status: ST_OK,
                                        is_status: 1'b0, last: 1'b0};
                        n_v = 2'd1;
                    end
                    if ((pos_e == 8'd2 && len_next == MIN_LEN) ||
                        (pos_e >= 8'd2 && len_next > MIN_LEN
                         && pos_w + 9'd3 == {1'b0, len_next})) begin
                        push_res[n_v] = '{out_byte: crc_next[7:0], status: ST_OK,
                                          is_status: 1'b0, last: 1'b0};
                        push_res[n_v + 2'd1] = '{out_byte: crc_next[15:8], status: ST_OK,
                                                 is_status: 1'b0, last: 1'b1};
                        n_v       = n_v + 2'd2;
                        done_next = 1'b1;
                    end
                end else begin
                    if (pos_e >= 8'd2 && pos_w + 9'd2 == {1'b0, len_next})
                        crc_lo_next = data_byte;
                    if (pos_e >= 8'd2 && pos_w + 9'd1 == {1'b0, len_next}) begin
                        st_v = ferr_next;
                        if (st_v == ST_OK &&
                            (crc_lo_next != crc_next[7:0] || data_byte != crc_next[15:8]))
                            st_v = ST_BAD_CRC;
                        push_res[0] = '{out_byte: 8'h00, status: st_v,
                                        is_status: 1'b1, last: 1'b1};
                        n_v       = 2'd1;
                        done_next = 1'b1;
                    end
                end

                if (pos_e != POS_MAX)
                    pos_next = pos_e + 8'd1;
            end
        end

        push_n = in_fire ? n_v : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg    <= 8'd0;
            len_reg    <= 8'd0;
            crc_reg    <= CRC_INIT;
            ferr_reg   <= ST_OK;
            crc_lo_reg <= 8'd0;
            done_reg   <= 1'b0;
        end else if (in_fire) begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            ferr_reg   <= ferr_next;
            crc_lo_reg <= crc_lo_next;
            done_reg   <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfcrc_fifo.sv =====
// Result queue: takes up to three results per cycle, hands out one per beat.
`default_nettype none

module sfcrc_fifo #(
    parameter int DEPTH = sfcrc_pkg::FIFO_DEPTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire [1:0]                    push_n,
    input  wire sfcrc_pkg::result_t      push_res [sfcrc_pkg::MAX_RES],
    input  wire                          pop,
    output logic                         can_push,
    output logic [$clog2(DEPTH+1)-1:0]   level,
    output sfcrc_pkg::result_t           head
);
    import sfcrc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;

    result_t            entries [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [LVL_W-1:0]   level_reg, level_next;

    // pointer advance with wrap at DEPTH
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [1:0] k);
        logic [SUM_W-1:0] s;
        s = {2'b00, p} + SUM_W'(k);
        if (s >= SUM_W'(DEPTH))
            s = s - SUM_W'(DEPTH);
        return s[PTR_W-1:0];
    endfunction

    assign level    = level_reg;
    assign can_push = (level_reg <= LVL_W'(DEPTH - MAX_RES));
    assign head     = entries[rptr_reg];

    always_comb
    begin
        level_next = level_reg + LVL_W'(push_n) - LVL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < push_n)
                entries[ptr_add(wptr_reg, 2'(k))] <= push_res[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end else begin
            wptr_reg  <= ptr_add(wptr_reg, push_n);
            rptr_reg  <= ptr_add(rptr_reg, {1'b0, pop});
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/frame_crc_monitor.sv =====
// CRC helper package and the output checker for the serial frame CRC-16 core.
`timescale 1ns / 100ps

package frame_crc_calc;
    import sfcrc_pkg::*;

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {8'h00, b};
        for (k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction
endpackage

module frame_crc_monitor (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    input  wire                              in_ready,
    input  wire  [7:0]                       data_byte,
    input  wire                              frame_start,
    input  wire                              out_valid,
    input  wire                              out_ready,
    input  wire  [7:0]                       out_byte,
    input  wire  [2:0]                       status,
    input  wire                              is_status,
    input  wire                              last,
    input  wire                              cfg_valid,
    input  wire                              cfg_ready,
    input  wire  [sfcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [sfcrc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                              end_check,
    output int                               errors,
    output int                               pending,
    output int                               bytes_seen,
    output int                               status_seen,
    output int                               ok_seen
);
    import sfcrc_pkg::*;
    import frame_crc_calc::*;

    logic [CMD_W-1:0] cmd_reg;
    logic             append_reg;

    int               pos;
    int               len_val;
    logic [15:0]      crc_acc;
    status_t          first_err;
    logic [7:0]       crc_lo_rx;
    logic             frame_over;

    result_t          due_results[$];
    result_t          oldest;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 40)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic restart_frame();
        pos        = 0;
        len_val    = 0;
        crc_acc    = CRC_INIT;
        first_err  = ST_OK;
        crc_lo_rx  = 8'h00;
        frame_over = 1'b0;
    endtask

    task automatic push_result(input logic [7:0] b, input status_t st, input logic is_st,
                               input logic lst);
        result_t r;
        r.out_byte  = b;
        r.status    = st;
        r.is_status = is_st;
        r.last      = lst;
        due_results.push_back(r);
    endtask

    task automatic track_frame_byte(input logic [7:0] b, input logic s);
        logic    covered;
        status_t st;
        if (s)
            restart_frame();
        if (frame_over)
            return;
        if (pos == 0 && b != SYNC_BYTE && first_err == ST_OK)
            first_err = ST_BAD_SYNC;
        if (pos == 3 && b[6:0] != cmd_reg && first_err == ST_OK)
            first_err = ST_BAD_CMD;
        if (pos == 2)
        begin
            len_val = int'(b);
            if (b < MIN_LEN)
            begin
                st = (!append_reg && first_err != ST_OK) ? first_err : ST_BAD_LEN;
                push_result(8'h00, st, 1'b1, 1'b1);
                frame_over = 1'b1;
                return;
            end
        end
        covered = (pos < 2) || (pos + 2 < len_val);
        if (covered)
            crc_acc = crc16_next(crc_acc, b);
        if (append_reg)
        begin
            if (covered)
                push_result(b, ST_OK, 1'b0, 1'b0);
            if ((pos == 2 && len_val == 4) || (pos >= 2 && len_val >= 5 && pos + 3 == len_val))
            begin
                push_result(crc_acc[7:0], ST_OK, 1'b0, 1'b0);
                push_result(crc_acc[15:8], ST_OK, 1'b0, 1'b1);
                frame_over = 1'b1;
            end
        end
        else
        begin
            if (pos >= 2 && pos + 2 == len_val)
                crc_lo_rx = b;
            if (pos >= 2 && pos + 1 == len_val)
            begin
                st = first_err;
                if (st == ST_OK && (crc_lo_rx != crc_acc[7:0] || b != crc_acc[15:8]))
                    st = ST_BAD_CRC;
                push_result(8'h00, st, 1'b1, 1'b1);
                frame_over = 1'b1;
            end
        end
        if (pos < 255)
            pos++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg    = '0;
            append_reg = 1'b0;
            restart_frame();
            due_results.delete();
            errors      = 0;
            pending     = 0;
            bytes_seen  = 0;
            status_seen = 0;
            ok_seen     = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                    report_mismatch("result beat with nothing expected", int'(out_byte), 0);
                else
                begin
                    oldest = due_results.pop_front();
                    if (out_byte !== oldest.out_byte)
                        report_mismatch("out_byte", int'(out_byte), int'(oldest.out_byte));
                    if (status !== oldest.status)
                        report_mismatch("status", int'(status), int'(oldest.status));
                    if (is_status !== oldest.is_status)
                        report_mismatch("is_status", int'(is_status), int'(oldest.is_status));
                    if (last !== oldest.last)
                        report_mismatch("last", int'(last), int'(oldest.last));
                    if (oldest.is_status)
                    begin
                        status_seen++;
                        if (oldest.status == ST_OK)
                            ok_seen++;
                    end
                    else
                        bytes_seen++;
                end
            end
            if (in_valid && in_ready)
                track_frame_byte(data_byte, frame_start);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_EXPECTED_COMMAND: cmd_reg    = cfg_data[CMD_W-1:0];
                    CFG_APPEND_MODE:      append_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (end_check && due_results.size() != 0)
                report_mismatch("results never delivered", due_results.size(), 0);
            pending = due_results.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the serial frame CRC-16 core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import sfcrc_pkg::*;
    import frame_crc_calc::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASE_ITEMS   = 16;
    localparam int NUM_PHASES    = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_SYNC,
        FLAW_CMD,
        FLAW_CRC_LO,
        FLAW_CRC_HI,
        FLAW_LEN,
        FLAW_TRUNC
    } flaw_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            data_byte;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            out_byte;
    logic [2:0]            status;
    logic                  is_status;
    logic                  last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  end_check;

    int errors;
    int pending;
    int bytes_seen;
    int status_seen;
    int ok_seen;

    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_go        = 0;
    int items_sent     = 0;

    logic [CMD_W-1:0] cur_cmd    = '0;
    logic             cur_append = 1'b0;
    logic [7:0]       frame_bytes[$];

    serial_frame_crc16_check_append_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .status      (status),
        .is_status   (is_status),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    frame_crc_monitor frame_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .status      (status),
        .is_status   (is_status),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .end_check   (end_check),
        .errors      (errors),
        .pending     (pending),
        .bytes_seen  (bytes_seen),
        .status_seen (status_seen),
        .ok_seen     (ok_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go != hold_seen)
            begin
                hold_seen = hold_go;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic s);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        frame_start <= s;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    task automatic send_frame(input logic with_start);
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
        begin
            send_beat(frame_bytes[i], with_start && i == 0);
            items_sent++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic [CMD_W-1:0] cmd, input logic app);
        wait_idle();
        write_reg(CFG_EXPECTED_COMMAND, {1'($urandom_range(0, 1)), cmd});
        write_reg(CFG_APPEND_MODE, {7'($urandom_range(0, 127)), app});
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_NO_REG, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        cur_cmd    = cmd;
        cur_append = app;
    endtask

    // overwrite the two trailing bytes with the CRC of the rest
    task automatic seal_crc();
        logic [15:0] crc;
        int          i;
        crc = CRC_INIT;
        for (i = 0; i < frame_bytes.size() - 2; i++)
            crc = crc16_next(crc, frame_bytes[i]);
        frame_bytes[frame_bytes.size() - 2] = crc[7:0];
        frame_bytes[frame_bytes.size() - 1] = crc[15:8];
    endtask

    task automatic make_frame(input int len, input flaw_t flaw);
        int n;
        int i;
        int cut;
        frame_bytes.delete();
        if (cur_append)
            n = (len < 5) ? 3 : len - 2;
        else
            n = (len < 4) ? 3 : len;
        for (i = 0; i < n; i++)
        begin
            case (i)
                0: frame_bytes.push_back(flaw == FLAW_SYNC ?
                                         SYNC_BYTE ^ 8'($urandom_range(1, 255)) : SYNC_BYTE);
                2: frame_bytes.push_back(8'(len));
                3: frame_bytes.push_back({1'($urandom_range(0, 1)),
                                          flaw == FLAW_CMD ?
                                          cur_cmd ^ 7'($urandom_range(1, 127)) : cur_cmd});
                default: frame_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if (!cur_append && len >= 6)
        begin
            seal_crc();
            if (flaw == FLAW_CRC_LO)
                frame_bytes[len - 2] = frame_bytes[len - 2] ^ 8'($urandom_range(1, 255));
            if (flaw == FLAW_CRC_HI)
                frame_bytes[len - 1] = frame_bytes[len - 1] ^ 8'($urandom_range(1, 255));
        end
        if (flaw == FLAW_TRUNC && n > 1)
        begin
            cut = $urandom_range(1, n - 1);
            repeat (cut) void'(frame_bytes.pop_back());
        end
    endtask

    task automatic random_frame();
        int    len;
        int    pick;
        flaw_t flaw;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            len = $urandom_range(4, 12);
        else if (pick < 95)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(41, 80);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            flaw = FLAW_NONE;
        else if (pick < 63)
            flaw = FLAW_SYNC;
        else if (pick < 71)
            flaw = FLAW_CMD;
        else if (pick < 78)
            flaw = FLAW_CRC_LO;
        else if (pick < 85)
            flaw = FLAW_CRC_HI;
        else if (pick < 92)
            flaw = FLAW_LEN;
        else
            flaw = FLAW_TRUNC;
        if (flaw == FLAW_LEN)
            len = $urandom_range(0, 3);
        make_frame(len, flaw);
        send_frame(1'b1);
        // stray bytes after a finished frame are dropped by the core
        if (flaw != FLAW_TRUNC && $urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial
    begin
        int ph;
        int target;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = 8'h00;
        frame_start = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        end_check   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // check mode at reset values; first frame comes without a start flag
        frame_bytes = '{SYNC_BYTE, 8'h00, 8'd6, 8'h80, 8'h00, 8'h00};
        seal_crc();
        send_frame(1'b0);
        frame_bytes = '{8'hFF, 8'hFF, 8'h03};
        send_frame(1'b1);
        send_beat(8'h00, 1'b0);
        frame_bytes = '{SYNC_BYTE, 8'h01, 8'h00};
        send_frame(1'b1);
        frame_bytes = '{SYNC_BYTE, 8'hFF, 8'd5, 8'h7F, 8'h12};
        send_frame(1'b1);
        frame_bytes = '{SYNC_BYTE, 8'h01, 8'hFF, 8'h00, 8'hFF};
        send_frame(1'b1);

        set_mode(7'h7F, 1'b1);
        frame_bytes = '{SYNC_BYTE, 8'hAB, 8'd4};
        send_frame(1'b1);
        frame_bytes = '{8'h00, 8'h00, 8'h02};
        send_frame(1'b1);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  set_mode(7'h7F, 1'b1); end
                1: begin send_idle_pct = 83; recv_stall_pct <= 0;  set_mode(7'h00, 1'b0); end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 83;
                         set_mode(7'($urandom_range(0, 127)), 1'b1); end
                3: begin send_idle_pct = 36; recv_stall_pct <= 36;
                         set_mode(7'($urandom_range(0, 127)), 1'b0); end
                4: begin send_idle_pct = 83; recv_stall_pct <= 0;
                         set_mode(7'($urandom_range(0, 127)), 1'b1); end
                5: begin send_idle_pct = 0;  recv_stall_pct <= 83; set_mode(7'h7F, 1'b0); end
                default: begin send_idle_pct = 36; recv_stall_pct <= 36;
                               set_mode(7'($urandom_range(0, 127)), 1'b1); end
            endcase
            if (ph == 0)
                hold_go <= hold_go + 1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                random_frame();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        end_check <= 1'b1;
        @(posedge clk);
        end_check <= 1'b0;
        @(negedge clk);
        $display("Sent %0d frame beats in check and append modes over %0d idle/stall phases,",
                 items_sent, NUM_PHASES);
        $display("with one long output hold-off; checked %0d bytes and %0d statuses (%0d ok).",
                 bytes_seen, status_seen, ok_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
